FILE: rtl/afp_pkg.sv
// Shared widths, register indexes and pipeline payload types for the placement core.
package afp_pkg;

    // Field widths
    localparam int SrcW  = 12;   // source image size
    localparam int PadW  = 10;   // paddings and margins
    localparam int ScrW  = 11;   // screen size registers
    localparam int BoxW  = 11;   // box and drawn sizes, left/top offsets
    localparam int PosW  = 12;   // origin coordinates
    localparam int FracW = 10;   // Q10 scale fraction
    localparam int CfgW  = 11;   // widest configuration register
    localparam int IdxW  = 3;    // configuration register index

    // Scale quotient and divider geometry
    localparam int QW        = BoxW + FracW;
    localparam int RemW      = SrcW;
    localparam int DivSteps  = 3;
    localparam int DivStages = QW / DivSteps;

    // Screen size used when the register holds zero
    localparam logic [ScrW-1:0] DefScreenWidth  = ScrW'(240);
    localparam logic [ScrW-1:0] DefScreenHeight = ScrW'(320);

    // Register indexes
    localparam logic [IdxW-1:0] RegScreenWidth  = IdxW'(0);
    localparam logic [IdxW-1:0] RegScreenHeight = IdxW'(1);
    localparam logic [IdxW-1:0] RegMarginLeft   = IdxW'(2);
    localparam logic [IdxW-1:0] RegMarginRight  = IdxW'(3);
    localparam logic [IdxW-1:0] RegMarginTop    = IdxW'(4);
    localparam logic [IdxW-1:0] RegMarginBottom = IdxW'(5);

    typedef struct packed {
        logic [ScrW-1:0] scr_w;
        logic [ScrW-1:0] scr_h;
        logic [PadW-1:0] mgn_l;
        logic [PadW-1:0] mgn_r;
        logic [PadW-1:0] mgn_t;
        logic [PadW-1:0] mgn_b;
    } afp_cfg_t;

    // Input request, last field in the lowest bits
    typedef struct packed {
        logic [PadW-1:0] lower_padding;
        logic [PadW-1:0] upper_padding;
        logic [PadW-1:0] side_padding;
        logic [SrcW-1:0] source_height;
        logic [SrcW-1:0] source_width;
    } afp_in_t;

    // Result, last field in the lowest bits
    typedef struct packed {
        logic [PosW-1:0] origin_y;
        logic [PosW-1:0] origin_x;
        logic [BoxW-1:0] drawn_height;
        logic [BoxW-1:0] drawn_width;
        logic [BoxW-1:0] box_height;
        logic [BoxW-1:0] box_width;
    } afp_res_t;

    // Box geometry carried down the pipeline
    typedef struct packed {
        logic [BoxW-1:0] aw;
        logic [BoxW-1:0] ah;
        logic [BoxW-1:0] left;
        logic [BoxW-1:0] top;
        logic [SrcW-1:0] srcw;
        logic [SrcW-1:0] srch;
    } afp_box_t;

    // Divider output: box plus both axis quotients
    typedef struct packed {
        afp_box_t        box;
        logic [QW-1:0]   qx;
        logic [QW-1:0]   qy;
    } afp_quo_t;

    localparam int InW    = $bits(afp_in_t);
    localparam int ResW   = $bits(afp_res_t);
    localparam int SDataW = ((InW + 7) / 8) * 8;
    localparam int MDataW = ((ResW + 7) / 8) * 8;

endpackage

FILE: rtl/afp_box.sv
// First pipeline stage: available box size and top-left offsets.
module afp_box (
    input  logic              aclk,
    input  logic              aresetn,
    input  afp_pkg::afp_cfg_t cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  afp_pkg::afp_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output afp_pkg::afp_box_t out_data
);
    import afp_pkg::*;

    logic            v_reg;
    afp_box_t        box_reg;
    afp_box_t        box_next;
    logic [ScrW-1:0] sw_eff;
    logic [ScrW-1:0] sh_eff;
    logic [PosW-1:0] sum_x;
    logic [PosW-1:0] sum_y;

    // Fall back to the default screen size and clamp the box to one pixel
    always_comb begin
        sw_eff = (cfg.scr_w == '0) ? DefScreenWidth  : cfg.scr_w;
        sh_eff = (cfg.scr_h == '0) ? DefScreenHeight : cfg.scr_h;
        sum_x  = PosW'(cfg.mgn_l) + PosW'(cfg.mgn_r)
               + PosW'({in_data.side_padding, 1'b0});
        sum_y  = PosW'(cfg.mgn_t) + PosW'(cfg.mgn_b)
               + PosW'(in_data.upper_padding) + PosW'(in_data.lower_padding);
        box_next.aw   = (PosW'(sw_eff) > sum_x) ? BoxW'(PosW'(sw_eff) - sum_x) : BoxW'(1);
        box_next.ah   = (PosW'(sh_eff) > sum_y) ? BoxW'(PosW'(sh_eff) - sum_y) : BoxW'(1);
        box_next.left = BoxW'(cfg.mgn_l) + BoxW'(in_data.side_padding);
        box_next.top  = BoxW'(cfg.mgn_t) + BoxW'(in_data.upper_padding);
        box_next.srcw = (in_data.source_width  == '0) ? SrcW'(1) : in_data.source_width;
        box_next.srch = (in_data.source_height == '0) ? SrcW'(1) : in_data.source_height;
    end

    assign in_ready  = !v_reg || out_ready;
    assign out_valid = v_reg;
    assign out_data  = box_reg;

    // Advance when the stage is empty or its request moves on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            box_reg <= box_next;
        end
    end

endmodule

FILE: rtl/afp_div.sv
// Pipelined restoring divider: box size * 1024 / source size on both axes.
module afp_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  afp_pkg::afp_box_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output afp_pkg::afp_quo_t out_data
);
    import afp_pkg::*;

    typedef struct packed {
        afp_box_t        box;
        logic [RemW-1:0] rem_x;
        logic [RemW-1:0] rem_y;
        logic [QW-1:0]   qn_x;
        logic [QW-1:0]   qn_y;
    } afp_div_t;

    logic [DivStages-1:0] v_reg;
    logic [DivStages-1:0] adv;
    logic [DivStages-1:0] v_in;
    afp_div_t             div_reg  [DivStages];
    afp_div_t             stg_in   [DivStages];
    afp_div_t             stg_next [DivStages];
    afp_div_t             init;

    // Several quotient bits per stage; the dividend shifts out as quotient shifts in
    function automatic afp_div_t div_step(input afp_div_t cur);
        afp_div_t        nxt;
        logic [RemW:0]   r1x;
        logic [RemW:0]   r1y;
        logic            gex;
        logic            gey;
        nxt = cur;
        for (int i = 0; i < DivSteps; i++) begin
            r1x = {nxt.rem_x, nxt.qn_x[QW-1]};
            r1y = {nxt.rem_y, nxt.qn_y[QW-1]};
            gex = r1x >= {1'b0, nxt.box.srcw};
            gey = r1y >= {1'b0, nxt.box.srch};
            nxt.rem_x = gex ? RemW'(r1x - {1'b0, nxt.box.srcw}) : r1x[RemW-1:0];
            nxt.rem_y = gey ? RemW'(r1y - {1'b0, nxt.box.srch}) : r1y[RemW-1:0];
            nxt.qn_x  = {nxt.qn_x[QW-2:0], gex};
            nxt.qn_y  = {nxt.qn_y[QW-2:0], gey};
        end
        return nxt;
    endfunction

    // Load the dividend as box size shifted up by the fraction width
    always_comb begin
        init.box   = in_data;
        init.rem_x = '0;
        init.rem_y = '0;
        init.qn_x  = {in_data.aw, FracW'(0)};
        init.qn_y  = {in_data.ah, FracW'(0)};
    end

    // Stage ready chain, from the output back
    always_comb begin
        adv[DivStages-1] = !v_reg[DivStages-1] || out_ready;
        for (int k = DivStages - 2; k >= 0; k--) begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    always_comb begin
        for (int k = 0; k < DivStages; k++) begin
            stg_in[k]   = (k == 0) ? init : div_reg[(k == 0) ? 0 : k - 1];
            v_in[k]     = (k == 0) ? in_valid : v_reg[(k == 0) ? 0 : k - 1];
            stg_next[k] = div_step(stg_in[k]);
        end
    end

    assign in_ready    = adv[0];
    assign out_valid   = v_reg[DivStages-1];
    assign out_data.box = div_reg[DivStages-1].box;
    assign out_data.qx  = div_reg[DivStages-1].qn_x;
    assign out_data.qy  = div_reg[DivStages-1].qn_y;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int k = 0; k < DivStages; k++) begin
                if (adv[k]) begin
                    v_reg[k] <= v_in[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < DivStages; k++) begin
            if (adv[k] && v_in[k]) begin
                div_reg[k] <= stg_next[k];
            end
        end
    end

`ifndef SYNTHESIS
    // Final remainder is below the divisor on both axes
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[DivStages-1] |-> (div_reg[DivStages-1].rem_x < div_reg[DivStages-1].box.srcw)
                            && (div_reg[DivStages-1].rem_y < div_reg[DivStages-1].box.srch))
        else $error("divider remainder not below divisor");
`endif

endmodule

FILE: rtl/afp_place.sv
// Placement pipeline: scale select, multiply, round and centre.
module afp_place (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  afp_pkg::afp_quo_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output afp_pkg::afp_res_t out_data
);
    import afp_pkg::*;

    localparam int PW = SrcW + QW;
    localparam logic [PW:0] RoundHalf = (PW + 1)'(1) << (FracW - 1);

    typedef struct packed {
        afp_box_t      box;
        logic [QW-1:0] scale;
    } afp_scl_t;

    typedef struct packed {
        afp_box_t      box;
        logic [PW-1:0] px;
        logic [PW-1:0] py;
    } afp_prod_t;

    typedef struct packed {
        afp_box_t        box;
        logic [BoxW-1:0] dw;
        logic [BoxW-1:0] dh;
    } afp_dim_t;

    logic [3:0]        v_reg;
    logic [3:0]        rdy;
    afp_scl_t          scl_reg,  scl_next;
    afp_prod_t         prod_reg, prod_next;
    afp_dim_t          dim_reg,  dim_next;
    afp_res_t          res_reg,  res_next;
    logic [QW-1:0]     qmin;
    logic [PW:0]       sum_x;
    logic [PW:0]       sum_y;
    logic [PW-FracW:0] rx;
    logic [PW-FracW:0] ry;
    logic [BoxW-1:0]   half_x;
    logic [BoxW-1:0]   half_y;

    // Ready chain, from the output register back
    always_comb begin
        rdy[3] = !v_reg[3] || out_ready;
        for (int k = 2; k >= 0; k--) begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    // Scale: smaller axis quotient, at least one
    always_comb begin
        qmin           = (in_data.qx < in_data.qy) ? in_data.qx : in_data.qy;
        scl_next.box   = in_data.box;
        scl_next.scale = (qmin == '0) ? QW'(1) : qmin;
    end

    // Multiply source size by the scale
    always_comb begin
        prod_next.box = scl_reg.box;
        prod_next.px  = PW'(scl_reg.box.srcw) * PW'(scl_reg.scale);
        prod_next.py  = PW'(scl_reg.box.srch) * PW'(scl_reg.scale);
    end

    // Round to nearest pixel, at least one
    always_comb begin
        sum_x        = (PW + 1)'(prod_reg.px) + RoundHalf;
        sum_y        = (PW + 1)'(prod_reg.py) + RoundHalf;
        rx           = sum_x[PW:FracW];
        ry           = sum_y[PW:FracW];
        dim_next.box = prod_reg.box;
        dim_next.dw  = (rx == '0) ? BoxW'(1) : rx[BoxW-1:0];
        dim_next.dh  = (ry == '0) ? BoxW'(1) : ry[BoxW-1:0];
    end

    // Centre the drawn image inside the box
    always_comb begin
        half_x = (dim_reg.box.aw > dim_reg.dw) ? ((dim_reg.box.aw - dim_reg.dw) >> 1) : '0;
        half_y = (dim_reg.box.ah > dim_reg.dh) ? ((dim_reg.box.ah - dim_reg.dh) >> 1) : '0;
        res_next.box_width    = dim_reg.box.aw;
        res_next.box_height   = dim_reg.box.ah;
        res_next.drawn_width  = dim_reg.dw;
        res_next.drawn_height = dim_reg.dh;
        res_next.origin_x     = PosW'(dim_reg.box.left) + PosW'(half_x);
        res_next.origin_y     = PosW'(dim_reg.box.top) + PosW'(half_y);
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[3];
    assign out_data  = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) v_reg[0] <= in_valid;
            if (rdy[1]) v_reg[1] <= v_reg[0];
            if (rdy[2]) v_reg[2] <= v_reg[1];
            if (rdy[3]) v_reg[3] <= v_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0] && in_valid) scl_reg  <= scl_next;
        if (rdy[1] && v_reg[0]) prod_reg <= prod_next;
        if (rdy[2] && v_reg[1]) dim_reg  <= dim_next;
        if (rdy[3] && v_reg[2]) res_reg  <= res_next;
    end

`ifndef SYNTHESIS
    // Selected scale is never zero
    a_scale_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[0] |-> scl_reg.scale != '0)
        else $error("scale is zero");

    // Drawn size stays within the box unless the scale was forced to one
    a_drawn_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[2] |-> (dim_reg.dw <= dim_reg.box.aw || dim_reg.dw <= BoxW'(4))
                  && (dim_reg.dh <= dim_reg.box.ah || dim_reg.dh <= BoxW'(4)))
        else $error("drawn size exceeds box");

    // Every result has nonzero box and drawn sizes
    a_res_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[3] |-> res_reg.drawn_width != '0 && res_reg.drawn_height != '0
                  && res_reg.box_width != '0 && res_reg.box_height != '0)
        else $error("zero size in result");
`endif

endmodule

FILE: rtl/aspect_fit_image_placement_core.sv
// Aspect-fit placement core: each request (source size and paddings) yields one result
// with the available box, the Q10-scaled drawn size and the centred origin. The core takes
// one request per clock while the output is not stalled; each result passes through
// one box stage, seven divider stages (21 quotient bits at three per stage,
// both axes side by side) and four placement stages (scale select, multiply, round, centre).
// Every stage holds its request under back-pressure, so an output stall fills the pipeline
// before s_tready drops. Configuration writes take effect on requests accepted afterwards.
module aspect_fit_image_placement_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration write port
    input  logic                        cfg_we,
    input  logic [afp_pkg::IdxW-1:0]    cfg_addr,
    input  logic [afp_pkg::CfgW-1:0]    cfg_wdata,
    // request channel
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // tdata: source_width, source_height, side_padding, upper_padding, lower_padding
    input  logic [afp_pkg::SDataW-1:0]  s_tdata,
    // result channel
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // tdata: box_width, box_height, drawn_width, drawn_height, origin_x, origin_y
    output logic [afp_pkg::MDataW-1:0]  m_tdata
);
    import afp_pkg::*;

    afp_cfg_t cfg_reg;
    afp_in_t  in_data;
    afp_box_t box_data;
    afp_quo_t quo_data;
    afp_res_t res_data;
    logic     box_valid, box_ready;
    logic     quo_valid, quo_ready;

    // Decode configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scr_w <= DefScreenWidth;
            cfg_reg.scr_h <= DefScreenHeight;
            cfg_reg.mgn_l <= '0;
            cfg_reg.mgn_r <= '0;
            cfg_reg.mgn_t <= '0;
            cfg_reg.mgn_b <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                RegScreenWidth:  cfg_reg.scr_w <= cfg_wdata[ScrW-1:0];
                RegScreenHeight: cfg_reg.scr_h <= cfg_wdata[ScrW-1:0];
                RegMarginLeft:   cfg_reg.mgn_l <= cfg_wdata[PadW-1:0];
                RegMarginRight:  cfg_reg.mgn_r <= cfg_wdata[PadW-1:0];
                RegMarginTop:    cfg_reg.mgn_t <= cfg_wdata[PadW-1:0];
                RegMarginBottom: cfg_reg.mgn_b <= cfg_wdata[PadW-1:0];
                default: ;
            endcase
        end
    end

    assign in_data = afp_in_t'(s_tdata[InW-1:0]);

    afp_box u_box (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (in_data),
        .out_valid (box_valid),
        .out_ready (box_ready),
        .out_data  (box_data)
    );

    afp_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (box_valid),
        .in_ready  (box_ready),
        .in_data   (box_data),
        .out_valid (quo_valid),
        .out_ready (quo_ready),
        .out_data  (quo_data)
    );

    afp_place u_place (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (quo_valid),
        .in_ready  (quo_ready),
        .in_data   (quo_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res_data)
    );

    assign m_tdata = {(MDataW - ResW)'(0), res_data};

endmodule
